/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, constants and helpers of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry and prompt length
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;
    localparam int PROMPT_LENGTH_DEF  = 8;

    // Word widths on the ports
    localparam int OP_W        = 2;
    localparam int IN_TDATA_W  = 24;   // char_code, read_row, read_column
    localparam int OUT_TDATA_W = 32;   // cursor_row, cursor_column, cell_char, cell_color
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 63;
    localparam int CELL_W      = 16;

    // Character and attribute codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;
    localparam logic [7:0] SPACE_CODE   = 8'd32;
    localparam logic [7:0] RESET_COLOR  = 8'd7;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLOR  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROMPT_TEXT = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE     = 2'd0,
        OP_BACKSPACE = 2'd1,
        OP_READ      = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_GLYPH,
        ST_ERASE,
        ST_READ,
        ST_SCROLL,
        ST_DRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    // Pick prompt character idx; the top byte only has seven stored bits
    function automatic logic [7:0] prompt_byte(input logic [CFG_DATA_W-1:0] text,
                                               input logic [2:0] idx);
        logic [CFG_DATA_W:0] word;
        word = {1'b0, text};
        return word[{idx, 3'b000} +: 8];
    endfunction

endpackage

/* design/tcw_screen_ram.sv */
// ----------------------------------------------------------------------------
// tcw_screen_ram
// Screen cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  logic                      aclk,
    input  logic                      we,
    input  logic [ADDR_W-1:0]         waddr,
    input  logic [tcw_pkg::CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0]         raddr,
    output logic [tcw_pkg::CELL_W-1:0] rdata
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* design/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console: screen cell memory, cursor, prompt after newline.
// ----------------------------------------------------------------------------
// A printable character, backspace or cell read passes through its work
// state and then DONE, which sends the result word; clear screen sweeps
// every cell first. A newline writes the PROMPT_LENGTH prompt characters,
// and each scroll it or a character causes copies the rows up through the
// single-port-pair cell memory, then blanks the bottom row.
// One word is in flight at a time. After reset (aresetn low, synchronous)
// the cell memory is swept to blank cells (2000 at 80x25) with s_tready held low.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF,
    parameter int PROMPT_LENGTH  = tcw_pkg::PROMPT_LENGTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Input words
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tcw_pkg::IN_TDATA_W-1:0]  s_tdata,   // char_code[7:0], read_row[12:8],
                                                       // read_column[19:13], zero fill
    input  logic [tcw_pkg::OP_W-1:0]        s_tuser,   // operation[1:0]
    // Result words
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata,   // cursor_row[4:0], cursor_column[11:5],
                                                       // cell_char[19:12], cell_color[27:20]
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS  = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int K_W    = $clog2(PROMPT_LENGTH + 1);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(SCREEN_COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'(CELLS - SCREEN_COLUMNS - 1);
    localparam logic [COL_W:0]    COLS_END    = (COL_W + 1)'(SCREEN_COLUMNS);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [K_W-1:0]    PROMPT_K    = K_W'(PROMPT_LENGTH);
    localparam logic [7:0]        PROMPT_TYPE = 8'(PROMPT_LENGTH);

    // State
    state_t                state_reg, state_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [7:0]            typed_reg, typed_next;
    logic [ADDR_W-1:0]     cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic                  prompt_mode_reg, prompt_mode_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [7:0]            char_reg, char_next;
    logic                  rd_ok_reg, rd_ok_next;
    logic [CELL_W-1:0]     cell_reg, cell_next;
    logic [7:0]            color_reg;
    logic [CFG_DATA_W-1:0] prompt_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // Memory port
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [CELL_W-1:0]     mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [CELL_W-1:0]     mem_rdata;

    // Input word fields
    op_t                   in_op;
    logic [7:0]            in_char;
    logic [4:0]            in_row;
    logic [6:0]            in_col;
    logic                  s_accept;
    logic                  out_free;

    // Cursor arithmetic
    logic [ADDR_W-1:0]     cur_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_ok;
    logic [COL_W:0]        col_inc;
    logic                  glyph_wrap;
    logic                  row_last;
    logic                  glyph_scroll;
    logic [K_W-1:0]        k_inc;
    logic                  more_after_glyph;
    logic                  prompt_more;
    logic                  cnt_last;
    logic [7:0]            glyph_char;
    logic [CELL_W-1:0]     blank_cell;

    assign in_op    = op_t'(s_tuser);
    assign in_char  = s_tdata[7:0];
    assign in_row   = s_tdata[12:8];
    assign in_col   = s_tdata[19:13];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign cur_addr = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign rd_addr  = ADDR_W'(in_row) * COLS_A + ADDR_W'(in_col);
    assign rd_ok    = (32'(in_row) < 32'(SCREEN_ROWS)) && (32'(in_col) < 32'(SCREEN_COLUMNS));

    assign col_inc          = {1'b0, col_reg} + 1'b1;
    assign glyph_wrap       = (col_inc == COLS_END);
    assign row_last         = (row_reg == LAST_ROW);
    assign glyph_scroll     = glyph_wrap && row_last;
    assign k_inc            = k_reg + 1'b1;
    assign more_after_glyph = prompt_mode_reg && (k_inc < PROMPT_K);
    assign prompt_more      = prompt_mode_reg && (k_reg < PROMPT_K);
    assign cnt_last         = (cnt_reg == LAST_CELL);
    assign glyph_char       = prompt_mode_reg ? prompt_byte(prompt_reg, 3'(k_reg)) : char_reg;
    assign blank_cell       = {color_reg, SPACE_CODE};

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: begin
                if (cnt_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        OP_WRITE: begin
                            if (in_char == NEWLINE_CODE && row_last) state_next = ST_SCROLL;
                            else                                     state_next = ST_GLYPH;
                        end
                        OP_BACKSPACE: state_next = ST_ERASE;
                        OP_READ:      state_next = ST_READ;
                        default:      state_next = ST_CLEAR;
                    endcase
                end
            end
            ST_GLYPH: begin
                if (glyph_scroll)          state_next = ST_SCROLL;
                else if (more_after_glyph) state_next = ST_GLYPH;
                else                       state_next = ST_DONE;
            end
            ST_SCROLL: begin
                if (cnt_reg == COPY_LAST) state_next = ST_DRAIN;
            end
            ST_DRAIN: state_next = ST_BLANK;
            ST_BLANK: begin
                if (cnt_last) state_next = prompt_more ? ST_GLYPH : ST_DONE;
            end
            ST_CLEAR: begin
                if (cnt_last) state_next = ST_DONE;
            end
            ST_ERASE: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        row_next         = row_reg;
        col_next         = col_reg;
        typed_next       = typed_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        prompt_mode_next = prompt_mode_reg;
        k_next           = k_reg;
        char_next        = char_reg;
        rd_ok_next       = rd_ok_reg;
        cell_next        = cell_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        mem_we           = 1'b0;
        mem_waddr        = cur_addr;
        mem_wdata        = blank_cell;
        mem_raddr        = cnt_reg + COLS_A;
        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = {RESET_COLOR, SPACE_CODE};
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_IDLE: begin
                mem_raddr = rd_addr;
                if (s_accept) begin
                    cell_next = '0;
                    cnt_next  = '0;
                    pend_next = 1'b0;
                    case (in_op)
                        OP_WRITE: begin
                            char_next = in_char;
                            if (in_char == NEWLINE_CODE) begin
                                typed_next       = PROMPT_TYPE;
                                prompt_mode_next = 1'b1;
                                k_next           = '0;
                                col_next         = '0;
                                if (!row_last) row_next = row_reg + 1'b1;
                            end else begin
                                prompt_mode_next = 1'b0;
                                if (typed_reg != 8'hFF) typed_next = typed_reg + 1'b1;
                            end
                        end
                        OP_BACKSPACE: begin
                            if (typed_reg != PROMPT_TYPE) begin
                                if (col_reg != '0)    col_next   = col_reg - 1'b1;
                                if (typed_reg != '0)  typed_next = typed_reg - 1'b1;
                            end
                        end
                        OP_READ: begin
                            rd_ok_next = rd_ok;
                        end
                        default: begin
                            row_next = '0;
                            col_next = '0;
                        end
                    endcase
                end
            end
            ST_GLYPH: begin
                mem_we    = 1'b1;
                mem_wdata = {color_reg, glyph_char};
                if (prompt_mode_reg) k_next = k_inc;
                if (glyph_wrap) begin
                    col_next = '0;
                    if (!row_last) row_next = row_reg + 1'b1;
                end else begin
                    col_next = col_inc[COL_W-1:0];
                end
                cnt_next  = '0;
                pend_next = 1'b0;
            end
            ST_SCROLL: begin
                // write back the row below, read one row ahead
                mem_we    = pend_reg;
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = mem_rdata;
                pend_next = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_DRAIN: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg - 1'b1;
                mem_wdata = mem_rdata;
            end
            ST_BLANK, ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                cnt_next  = cnt_reg + 1'b1;
            end
            ST_ERASE: begin
                mem_we = 1'b1;
            end
            ST_READ: begin
                cell_next = rd_ok_reg ? mem_rdata : '0;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, cell_reg, 7'(col_reg), 5'(row_reg)};
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_INIT;
            row_reg         <= '0;
            col_reg         <= '0;
            typed_reg       <= '0;
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            prompt_mode_reg <= 1'b0;
            k_reg           <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            typed_reg       <= typed_next;
            cnt_reg         <= cnt_next;
            pend_reg        <= pend_next;
            prompt_mode_reg <= prompt_mode_next;
            k_reg           <= k_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        char_reg    <= char_next;
        rd_ok_reg   <= rd_ok_next;
        cell_reg    <= cell_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg  <= RESET_COLOR;
            prompt_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TEXT_COLOR:  color_reg  <= cfg_data[7:0];
                CFG_PROMPT_TEXT: prompt_reg <= cfg_data;
                default:         color_reg  <= color_reg;
            endcase
        end
    end

    tcw_screen_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

/* design/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [tcw_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import tcw_pkg::*;

    // Reset starts the clearing sweep, so no word is taken next cycle
    assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input accepted right after reset");

    // One word in flight: an accept closes the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in flight");

    // Stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word changed");

    // Reported cursor stays on the screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((32'(m_tdata[4:0]) < 32'(SCREEN_ROWS)) &&
                      (32'(m_tdata[11:5]) < 32'(SCREEN_COLUMNS))))
        else $error("cursor off screen");

endmodule

bind text_console_writer tcw_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
